>>> rtl/matrix_inverse_4x4_assert.svh
// Assertion macros shared by the matrix inverse RTL.
`ifndef MATRIX_INVERSE_4X4_ASSERT_SVH
`define MATRIX_INVERSE_4X4_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled in reset.
`define MI4_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("matrix inverse check failed");

// Next-cycle implication, checked on clk and disabled in reset.
`define MI4_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("matrix inverse check failed");

`endif

>>> rtl/mi4_pkg.sv
// Types and helpers shared by the matrix inverse block and its arithmetic unit.
package mi4_pkg;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

  // Index n (0..2) of the three rows or columns that remain when idx is removed.
  function automatic logic [1:0] other_idx(input logic [1:0] idx, input logic [1:0] n);
    other_idx = (n < idx) ? n : n + 2'd1;
  endfunction

endpackage

>>> rtl/mi4_alu.sv
// Shared iterative unit: serial shift-add multiplier and restoring divider.
module mi4_alu #(
  parameter int ELEMENT_WIDTH = 32,
  parameter int FRAC_BITS = 16,
  localparam int AW = 4 * ELEMENT_WIDTH + 5,
  localparam int NW = 3 * ELEMENT_WIDTH + 3 + 2 * FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mi4_pkg::alu_req_t        req,
  input  logic [AW-1:0]            a,
  input  logic [ELEMENT_WIDTH-1:0] b,
  input  logic [NW-1:0]            num,
  input  logic [AW-1:0]            den,
  output mi4_pkg::alu_sts_t        sts,
  output logic [AW-1:0]            prod,
  output logic [NW-1:0]            quo
);
  import mi4_pkg::*;

  localparam int W   = ELEMENT_WIDTH;
  localparam int CNW = $clog2(NW + 1);

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_MUL  = 4'b0010,
    U_DIV  = 4'b0100,
    U_RND  = 4'b1000
  } ustate_t;

  ustate_t        ust_r, ust_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           done_r, done_nxt;
  logic [AW-1:0]  acc_r, acc_nxt;
  logic [AW-1:0]  sh_r, sh_nxt;
  logic [W-1:0]   mb_r, mb_nxt;
  logic [AW-1:0]  rem_r, rem_nxt;
  logic [NW-1:0]  nq_r, nq_nxt;
  logic [AW-1:0]  den_r, den_nxt;

  logic          last_bit;
  logic [AW-1:0] addend;
  logic [AW:0]   rem_sh;
  logic [AW:0]   rem_diff;
  logic          rem_ge;
  logic          rnd_up;

  always_comb begin
    ust_nxt  = ust_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    mb_nxt   = mb_r;
    rem_nxt  = rem_r;
    nq_nxt   = nq_r;
    den_nxt  = den_r;

    last_bit = (cnt_r == CNW'(1));
    // The top multiplier bit carries negative weight, so it subtracts.
    addend   = last_bit ? ~sh_r : sh_r;
    rem_sh   = {rem_r, nq_r[NW-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    rem_ge   = (rem_sh >= {1'b0, den_r});
    rnd_up   = ({rem_r, 1'b0} >= {1'b0, den_r});

    unique case (ust_r)
      U_IDLE: begin
        if (req.start) begin
          if (req.op == ALU_MUL) begin
            acc_nxt = '0;
            sh_nxt  = a;
            mb_nxt  = b;
            cnt_nxt = CNW'(W);
            ust_nxt = U_MUL;
          end else begin
            rem_nxt = '0;
            nq_nxt  = num;
            den_nxt = den;
            cnt_nxt = CNW'(NW);
            ust_nxt = U_DIV;
          end
        end
      end
      U_MUL: begin
        if (mb_r[0]) begin
          acc_nxt = acc_r + addend + AW'(last_bit);
        end
        sh_nxt  = {sh_r[AW-2:0], 1'b0};
        mb_nxt  = {1'b0, mb_r[W-1:1]};
        cnt_nxt = cnt_r - CNW'(1);
        if (last_bit) begin
          ust_nxt  = U_IDLE;
          done_nxt = 1'b1;
        end
      end
      U_DIV: begin
        rem_nxt = rem_ge ? rem_diff[AW-1:0] : rem_sh[AW-1:0];
        nq_nxt  = {nq_r[NW-2:0], rem_ge};
        cnt_nxt = cnt_r - CNW'(1);
        if (last_bit) begin
          ust_nxt = U_RND;
        end
      end
      U_RND: begin
        // Round half up on the magnitude.
        nq_nxt   = nq_r + NW'(rnd_up);
        ust_nxt  = U_IDLE;
        done_nxt = 1'b1;
      end
      default: begin
        ust_nxt = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ust_r  <= U_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      ust_r  <= ust_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    mb_r  <= mb_nxt;
    rem_r <= rem_nxt;
    nq_r  <= nq_nxt;
    den_r <= den_nxt;
  end

  assign sts.busy = (ust_r != U_IDLE);
  assign sts.done = done_r;
  assign prod     = acc_r;
  assign quo      = nq_r;

endmodule

>>> rtl/matrix_inverse_4x4.sv
// 4x4 fixed-point matrix inverse by the adjugate, on one shared serial unit.
// Loading takes one item per cycle; the sixteenth item starts the computation.
// Cofactors and determinant need 148 serial multiplies on the shared unit.
// Each of the 16 results needs one division on the same unit, none if the matrix is singular.
// The shared unit sets the pace; a new matrix loads only after the last result is registered.
// Synchronous active-low reset clears the load count, sequencer and output valid.
`include "matrix_inverse_4x4_assert.svh"

module matrix_inverse_4x4 #(
  parameter int ELEMENT_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [ELEMENT_WIDTH-1:0] in_element,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [ELEMENT_WIDTH-1:0] out_inverse_element,
  output logic [3:0]                      out_element_index,
  output logic                            out_singular,
  output logic                            out_saturated,
  output logic                            out_last
);
  import mi4_pkg::*;

  localparam int W  = ELEMENT_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int AW = 4 * W + 5;
  localparam int CW = 3 * W + 3;
  localparam int NW = CW + 2 * F;

  localparam logic [NW-1:0] LIM_POS = {{(NW - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic [NW-1:0] LIM_NEG = NW'(1) << (W - 1);
  localparam logic [W-1:0]  MAX_POS = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0]  MAX_NEG = {1'b1, {(W - 1){1'b0}}};
  localparam logic          ONE_SAT = (F >= W - 1);
  localparam logic [W-1:0]  ONE_VAL = (F >= W - 1) ? MAX_POS : (W'(1) << F);

  typedef enum logic [7:0] {
    ST_LOAD   = 8'b00000001,
    ST_FETCH  = 8'b00000010,
    ST_START  = 8'b00000100,
    ST_WAIT   = 8'b00001000,
    ST_DMAG   = 8'b00010000,
    ST_DSTART = 8'b00100000,
    ST_DWAIT  = 8'b01000000,
    ST_RES    = 8'b10000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic [3:0]    k_r, k_nxt;
  logic [1:0]    j_r, j_nxt;
  logic [1:0]    t_r, t_nxt;
  logic          det_ph_r, det_ph_nxt;
  logic          singular_r, singular_nxt;
  logic          cneg_r, cneg_nxt;
  logic [AW-1:0] opa_r, opa_nxt;
  logic [AW-1:0] minor_r, minor_nxt;
  logic [AW-1:0] cof_acc_r, cof_acc_nxt;
  logic [AW-1:0] det_r, det_nxt;
  logic [AW-1:0] dmag_r, dmag_nxt;

  logic [W-1:0]  store_r [16];
  logic [CW-1:0] cof_r [16];

  logic          out_valid_r, out_valid_nxt;
  logic [W-1:0]  out_val_r, out_val_nxt;
  logic [3:0]    out_idx_r, out_idx_nxt;
  logic          out_sing_r, out_sing_nxt;
  logic          out_sat_r, out_sat_nxt;
  logic          out_last_r, out_last_nxt;

  alu_req_t      alu_req;
  alu_sts_t      alu_sts;
  logic [AW-1:0] alu_prod;
  logic [NW-1:0] alu_quo;
  logic [NW-1:0] div_num;

  logic          in_fire;
  logic          cof_wr;
  logic [3:0]    st_addr;
  logic [W-1:0]  st_rd;
  logic [3:0]    cof_addr;
  logic [CW-1:0] cof_rd;
  logic [CW-1:0] cof_mag;
  logic [1:0]    row, col, r0, r1, r2, ca, cb, cj;
  logic          term_neg;
  logic [AW-1:0] cof_base;
  logic          slot_free;
  logic          res_sat;
  logic [W-1:0]  res_val;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (state_r == ST_LOAD);
  assign slot_free = !out_valid_r || out_ready;

  // Minor and element addressing for cofactor k: element (r, c) lives at c*4+r.
  always_comb begin
    row = k_r[3:2];
    col = k_r[1:0];
    r0  = other_idx(row, 2'd0);
    r1  = other_idx(row, 2'd1);
    r2  = other_idx(row, 2'd2);
    cj  = other_idx(col, j_r);
    ca  = other_idx(col, (j_r == 2'd0) ? 2'd1 : 2'd0);
    cb  = other_idx(col, (j_r == 2'd2) ? 2'd1 : 2'd2);

    st_addr = {ca, r1};
    if (state_r == ST_FETCH) begin
      st_addr = (t_r == 2'd0) ? {ca, r1} : {cb, r1};
    end else if (det_ph_r) begin
      st_addr = {2'b00, k_r[1:0]};
    end else begin
      case (t_r)
        2'd0:    st_addr = {cb, r2};
        2'd1:    st_addr = {ca, r2};
        default: st_addr = {cj, r0};
      endcase
    end
    st_rd = store_r[st_addr];

    cof_addr = (state_r == ST_FETCH) ? {k_r[1:0], 2'b00} : k_r;
    cof_rd   = cof_r[cof_addr];
    cof_mag  = cof_rd[CW-1] ? (~cof_rd + CW'(1)) : cof_rd;
    div_num  = {cof_mag, {(2 * F){1'b0}}};
  end

  mi4_alu #(
    .ELEMENT_WIDTH(ELEMENT_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (alu_req),
    .a    (opa_r),
    .b    (st_rd),
    .num  (div_num),
    .den  (dmag_r),
    .sts  (alu_sts),
    .prod (alu_prod),
    .quo  (alu_quo)
  );

  // Result formatting: identity for a singular matrix, else saturate the rounded magnitude and apply the sign.
  always_comb begin
    res_val = '0;
    res_sat = 1'b0;
    if (singular_r) begin
      if (k_r[3:2] == k_r[1:0]) begin
        res_val = ONE_VAL;
        res_sat = ONE_SAT;
      end
    end else if (!cneg_r) begin
      if (alu_quo > LIM_POS) begin
        res_val = MAX_POS;
        res_sat = 1'b1;
      end else begin
        res_val = alu_quo[W-1:0];
      end
    end else begin
      if (alu_quo > LIM_NEG) begin
        res_val = MAX_NEG;
        res_sat = 1'b1;
      end else begin
        res_val = ~alu_quo[W-1:0] + W'(1);
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    k_nxt        = k_r;
    j_nxt        = j_r;
    t_nxt        = t_r;
    det_ph_nxt   = det_ph_r;
    singular_nxt = singular_r;
    cneg_nxt     = cneg_r;
    opa_nxt      = opa_r;
    minor_nxt    = minor_r;
    cof_acc_nxt  = cof_acc_r;
    det_nxt      = det_r;
    dmag_nxt     = dmag_r;
    cof_wr       = 1'b0;
    alu_req      = '{start: 1'b0, op: ALU_MUL};

    out_valid_nxt = out_valid_r && !out_ready;
    out_val_nxt   = out_val_r;
    out_idx_nxt   = out_idx_r;
    out_sing_nxt  = out_sing_r;
    out_sat_nxt   = out_sat_r;
    out_last_nxt  = out_last_r;

    // Sign of term j in the cofactor expansion, folded with the checkerboard sign.
    term_neg = (j_r == 2'd1) ^ k_r[2] ^ k_r[0];
    cof_base = (j_r == 2'd0) ? '0 : cof_acc_r;

    unique case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            k_nxt      = '0;
            j_nxt      = '0;
            t_nxt      = '0;
            det_ph_nxt = 1'b0;
            state_nxt  = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        if (det_ph_r) begin
          opa_nxt = {{(AW - CW){cof_rd[CW-1]}}, cof_rd};
        end else if (t_r == 2'd2) begin
          opa_nxt = minor_r;
        end else begin
          opa_nxt = {{(AW - W){st_rd[W-1]}}, st_rd};
        end
        state_nxt = ST_START;
      end
      ST_START: begin
        alu_req   = '{start: 1'b1, op: ALU_MUL};
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (alu_sts.done) begin
          state_nxt = ST_FETCH;
          if (det_ph_r) begin
            det_nxt = ((k_r[1:0] == 2'd0) ? '0 : det_r) + alu_prod;
            k_nxt   = k_r + 4'd1;
            if (k_r[1:0] == 2'd3) begin
              k_nxt     = '0;
              state_nxt = ST_DMAG;
            end
          end else if (t_r == 2'd0) begin
            minor_nxt = alu_prod;
            t_nxt     = 2'd1;
          end else if (t_r == 2'd1) begin
            minor_nxt = minor_r - alu_prod;
            t_nxt     = 2'd2;
          end else begin
            cof_acc_nxt = cof_base + (term_neg ? ~alu_prod : alu_prod) + AW'(term_neg);
            t_nxt       = 2'd0;
            j_nxt       = j_r + 2'd1;
            if (j_r == 2'd2) begin
              j_nxt  = '0;
              cof_wr = 1'b1;
              k_nxt  = k_r + 4'd1;
              if (k_r == 4'd15) begin
                det_ph_nxt = 1'b1;
              end
            end
          end
        end
      end
      ST_DMAG: begin
        singular_nxt = (det_r == '0);
        dmag_nxt     = det_r[AW-1] ? (~det_r + AW'(1)) : det_r;
        state_nxt    = ST_DSTART;
      end
      ST_DSTART: begin
        if (singular_r) begin
          state_nxt = ST_RES;
        end else begin
          cneg_nxt  = cof_rd[CW-1];
          alu_req   = '{start: 1'b1, op: ALU_DIV};
          state_nxt = ST_DWAIT;
        end
      end
      ST_DWAIT: begin
        if (alu_sts.done) begin
          state_nxt = ST_RES;
        end
      end
      ST_RES: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val;
          out_idx_nxt   = k_r;
          out_sing_nxt  = singular_r;
          out_sat_nxt   = res_sat;
          out_last_nxt  = (k_r == 4'd15);
          k_nxt         = k_r + 4'd1;
          state_nxt     = (k_r == 4'd15) ? ST_LOAD : ST_DSTART;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      k_r         <= '0;
      j_r         <= '0;
      t_r         <= '0;
      det_ph_r    <= 1'b0;
      singular_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      t_r         <= t_nxt;
      det_ph_r    <= det_ph_nxt;
      singular_r  <= singular_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cneg_r     <= cneg_nxt;
    opa_r      <= opa_nxt;
    minor_r    <= minor_nxt;
    cof_acc_r  <= cof_acc_nxt;
    det_r      <= det_nxt;
    dmag_r     <= dmag_nxt;
    out_val_r  <= out_val_nxt;
    out_idx_r  <= out_idx_nxt;
    out_sing_r <= out_sing_nxt;
    out_sat_r  <= out_sat_nxt;
    out_last_r <= out_last_nxt;
    if (in_fire) begin
      store_r[cnt_r] <= in_element;
    end
    if (cof_wr) begin
      cof_r[k_r] <= cof_acc_nxt[CW-1:0];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_inverse_element = out_val_r;
  assign out_element_index   = out_idx_r;
  assign out_singular        = out_sing_r;
  assign out_saturated       = out_sat_r;
  assign out_last            = out_last_r;

  `MI4_CHECK(a_start_idle, state_r == ST_START || (state_r == ST_DSTART && !singular_r), !alu_sts.busy)
  `MI4_CHECK(a_done_in_wait, alu_sts.done, state_r == ST_WAIT || state_r == ST_DWAIT)
  `MI4_CHECK_NEXT(a_res_hold, state_r == ST_RES && out_valid_r && !out_ready, state_r == ST_RES && $stable(k_r))
  `MI4_CHECK_NEXT(a_last_load, state_r == ST_RES && k_r == 4'd15 && slot_free, state_r == ST_LOAD && out_valid_r && out_last_r)

endmodule

>>> dv/matrix_inverse_4x4_checker.sv
// Result checker for the 4x4 matrix inverse: predicts each inverse and compares every element.
`timescale 1ns / 1ps

module matrix_inverse_4x4_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] in_element,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_inverse_element,
  input  logic [3:0]         out_element_index,
  input  logic               out_singular,
  input  logic               out_saturated,
  input  logic               out_last,
  output int                 error_count,
  output int                 pending_count
);

  localparam int FRAC = 16;

  typedef logic signed [255:0] big_t;

  typedef struct {
    logic signed [31:0] value;
    logic [3:0]         index;
    logic               singular;
    logic               saturated;
    logic               last;
  } inv_elem_t;

  logic signed [31:0] matrix_shadow [16];
  int                 loaded;
  inv_elem_t          inverse_queue [$];

  function automatic big_t elem_at(input int row, input int col);
    elem_at = big_t'(matrix_shadow[(col * 4 + row) & 15]);
  endfunction

  function automatic big_t minor2(input int ra, input int rb, input int ca, input int cb);
    minor2 = elem_at(ra, ca) * elem_at(rb, cb) - elem_at(ra, cb) * elem_at(rb, ca);
  endfunction

  function automatic big_t cofactor_of(input int row, input int col);
    int   r [3];
    int   c [3];
    int   n;
    big_t s;
    n = 0;
    for (int i = 0; i < 4; i++) if (i != row) begin r[n] = i; n++; end
    n = 0;
    for (int i = 0; i < 4; i++) if (i != col) begin c[n] = i; n++; end
    s = elem_at(r[0], c[0]) * minor2(r[1], r[2], c[1], c[2])
      - elem_at(r[0], c[1]) * minor2(r[1], r[2], c[0], c[2])
      + elem_at(r[0], c[2]) * minor2(r[1], r[2], c[0], c[1]);
    cofactor_of = ((row + col) & 1) ? -s : s;
  endfunction

  // Forms the adjugate and determinant exactly, then rounds each quotient once.
  task automatic predict_inverse();
    big_t       cof [16];
    big_t       det;
    logic [255:0] dmag, num, quo, rem;
    logic       neg;
    inv_elem_t  e;
    for (int k = 0; k < 16; k++) cof[k] = cofactor_of(k >> 2, k & 3);
    det = '0;
    for (int i = 0; i < 4; i++) det = det + elem_at(i, 0) * cof[i * 4];
    dmag = (det < 0) ? -det : det;
    for (int k = 0; k < 16; k++) begin
      e.index = k[3:0];
      e.last = (k == 15);
      e.singular = (det == 0);
      e.saturated = 1'b0;
      if (det == 0) begin
        e.value = ((k >> 2) == (k & 3)) ? 32'sd1 <<< FRAC : 32'sd0;
      end else begin
        neg = cof[k] < 0;
        num = (neg ? -cof[k] : cof[k]) << (2 * FRAC);
        quo = num / dmag;
        rem = num % dmag;
        if ((rem << 1) >= dmag) quo = quo + 1;
        if (!neg && quo > 256'h7FFF_FFFF) begin
          e.value = 32'h7FFF_FFFF;
          e.saturated = 1'b1;
        end else if (neg && quo > 256'h8000_0000) begin
          e.value = 32'h8000_0000;
          e.saturated = 1'b1;
        end else begin
          e.value = neg ? -quo[31:0] : quo[31:0];
        end
      end
      inverse_queue.push_back(e);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("matrix_inverse_4x4_checker: mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  initial begin
    error_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    inv_elem_t x;
    if (!rst_n) begin
      loaded = 0;
      inverse_queue.delete();
    end else begin
      if (in_valid && in_ready) begin
        matrix_shadow[loaded] = in_element;
        loaded++;
        if (loaded == 16) begin
          loaded = 0;
          predict_inverse();
        end
      end
      if (out_valid && out_ready) begin
        if (inverse_queue.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          x = inverse_queue.pop_front();
          if (out_inverse_element !== x.value)
            report_mismatch($sformatf("index %0d value %h, expected %h",
                                      x.index, out_inverse_element, x.value));
          if (out_element_index !== x.index)
            report_mismatch($sformatf("index %0d, expected %0d", out_element_index, x.index));
          if (out_singular !== x.singular)
            report_mismatch($sformatf("index %0d singular flag %b", x.index, out_singular));
          if (out_saturated !== x.saturated)
            report_mismatch($sformatf("index %0d saturated flag %b", x.index, out_saturated));
          if (out_last !== x.last)
            report_mismatch($sformatf("index %0d last flag %b", x.index, out_last));
        end
      end
    end
    pending_count = inverse_queue.size();
  end

endmodule

>>> dv/matrix_inverse_4x4_test.sv
// Testbench top for the 4x4 matrix inverse: drives matrices, stalls results, gives the verdict.
`timescale 1ns / 1ps

module matrix_inverse_4x4_test;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_element;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_inverse_element;
  logic [3:0]         out_element_index;
  logic               out_singular;
  logic               out_saturated;
  logic               out_last;
  int                 error_count;
  int                 pending_count;
  bit                 steady;
  logic signed [31:0] matrix_buf [16];

  matrix_inverse_4x4 dut (.*);

  matrix_inverse_4x4_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Gives up long after the slowest correct run would have ended.
  initial begin
    #5ms;
    $display("matrix_inverse_4x4_test: errors");
    $finish;
  end

  // Valid drops only when a gap follows, so back-to-back items keep it high.
  task automatic send_element(input logic signed [31:0] value);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_element <= value;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_matrix();
    for (int k = 0; k < 16; k++) send_element(matrix_buf[k]);
    release_input();
  endtask

  // Random matrix of one kind: full-range bits, values within 0x20000 of zero, or small values made rank deficient.
  task automatic build_random_matrix(input int kind);
    int src;
    for (int k = 0; k < 16; k++) begin
      case (kind)
        0:       matrix_buf[k] = $urandom;
        1:       matrix_buf[k] = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        default: matrix_buf[k] = $signed($urandom_range(0, 2000)) - 1000;
      endcase
    end
    if (kind == 2) begin
      // Copy one column onto another so the determinant is exactly zero.
      src = $urandom_range(0, 3);
      for (int r = 0; r < 4; r++) matrix_buf[((src + 1) % 4) * 4 + r] = matrix_buf[src * 4 + r];
    end
  endtask

  // Result side: a fresh random stall, possibly none, before each result, except in steady stretches.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = steady ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_element = '0;
    steady = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Extreme diagonal: tiny entries invert past the range and saturate.
    for (int k = 0; k < 16; k++) matrix_buf[k] = '0;
    matrix_buf[0]  = 32'sh7FFF_FFFF;
    matrix_buf[5]  = 32'sh8000_0000;
    matrix_buf[10] = 32'sd1;
    matrix_buf[15] = -32'sd1;
    send_matrix();

    // Hold off until the whole inverse has drained.
    while (pending_count != 0) @(negedge clk);

    for (int m = 0; m < 7; m++) begin
      steady = (m == 3);
      build_random_matrix(m % 4 == 3 ? 0 : m % 3);
      send_matrix();
    end
    // A trailing partial matrix leaves elements loaded but nothing expected.
    steady = 1'b0;
    for (int k = 0; k < 3; k++) send_element(matrix_buf[k]);
    release_input();

    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (error_count == 0) begin
      $display("matrix_inverse_4x4_test: clean");
    end else begin
      $display("matrix_inverse_4x4_test: errors");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/mi4_pkg.sv
rtl/mi4_alu.sv
rtl/matrix_inverse_4x4.sv
dv/matrix_inverse_4x4_checker.sv
dv/matrix_inverse_4x4_test.sv
